>>> rtl/core/plf_pkg.sv
// Shared types, constants and helpers for the Playfair digraph encryptor.
package plf_pkg;

    localparam int LETTER_W        = 5;
    localparam int ALPHABET        = 26;
    localparam int SQUARE_SIDE_DEF = 5;

    localparam logic [LETTER_W-1:0] CODE_I = LETTER_W'(8);
    localparam logic [LETTER_W-1:0] CODE_J = LETTER_W'(9);
    localparam logic [LETTER_W-1:0] CODE_Z = LETTER_W'(25);

    typedef enum logic [1:0] {
        FUNC_START   = 2'd0,
        FUNC_KEY     = 2'd1,
        FUNC_FINISH  = 2'd2,
        FUNC_ENCRYPT = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_LOOKUP
    } state_t;

    typedef struct packed {
        func_t               func;
        logic [LETTER_W-1:0] letter_a;
        logic [LETTER_W-1:0] letter_b;
    } item_t;

    typedef struct packed {
        logic [LETTER_W-1:0] cipher_a;
        logic [LETTER_W-1:0] cipher_b;
        logic                not_ready;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic clear;
        logic place_key;
        logic scan_start;
        logic scan_step;
        logic set_ready;
        logic lookup;
        logic cell_read;
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic ready;
        logic scan_last;
    } ctl_stat_t;

    // Text letter: saturate to Z, fold J into I.
    function automatic logic [LETTER_W-1:0] fold_text(input logic [LETTER_W-1:0] v);
        logic [LETTER_W-1:0] c;
        c = (v > CODE_Z) ? CODE_Z : v;
        if (c == CODE_J) c = CODE_I;
        return c;
    endfunction

endpackage

>>> rtl/core/plf_ctrl.sv
// Sequencer for the Playfair encryptor: decodes requests, runs fill and lookup.
module plf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  plf_pkg::func_t    func,
    input  plf_pkg::ctl_stat_t stat,
    output logic              busy,
    output logic              result_valid,
    output plf_pkg::ctl_cmd_t cmd
);
    import plf_pkg::*;

    state_t state_reg, state_next;
    logic   valid_reg, valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        valid_next = (state_reg == ST_LOOKUP);
        busy       = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (func)
                        FUNC_START:   cmd.clear = 1'b1;
                        FUNC_KEY:     cmd.place_key = 1'b1;
                        FUNC_FINISH:
                        begin
                            if (!stat.ready)
                            begin
                                cmd.scan_start = 1'b1;
                                state_next     = ST_FILL;
                            end
                        end
                        FUNC_ENCRYPT:
                        begin
                            cmd.lookup = 1'b1;
                            state_next = ST_LOOKUP;
                        end
                        default: ;
                    endcase
                end
            end
            ST_FILL:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    cmd.set_ready = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_LOOKUP:
            begin
                cmd.cell_read = 1'b1;
                state_next    = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign result_valid = valid_reg;

endmodule

>>> rtl/core/plf_datapath.sv
// Key square storage, letter position table, fill logic and pair mapping.
module plf_datapath #(
    parameter int SQUARE_SIDE = plf_pkg::SQUARE_SIDE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  plf_pkg::item_t     item,
    input  plf_pkg::ctl_cmd_t  cmd,
    output plf_pkg::ctl_stat_t stat,
    output plf_pkg::result_t   result
);
    import plf_pkg::*;

    localparam int CELLS   = SQUARE_SIDE * SQUARE_SIDE;
    localparam int SIDE_W  = (SQUARE_SIDE > 1) ? $clog2(SQUARE_SIDE) : 1;
    localparam int CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CNT_W   = $clog2(CELLS + 1);
    localparam logic [SIDE_W-1:0] SIDE_LAST = SIDE_W'(SQUARE_SIDE - 1);
    localparam logic [CNT_W-1:0]  CELLS_CNT = CNT_W'(CELLS);

    typedef struct packed {
        logic [SIDE_W-1:0] row;
        logic [SIDE_W-1:0] col;
    } pos_t;

    // storage
    logic [LETTER_W-1:0] cells_mem [CELLS];
    pos_t                pos_mem   [ALPHABET];

    // control state
    logic [ALPHABET-1:0] used_reg, used_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [SIDE_W-1:0]   row_reg, row_next, col_reg, col_next;
    logic                ready_reg, ready_next;
    logic [LETTER_W-1:0] scan_reg, scan_next;

    // payload
    pos_t                pa_reg, pb_reg;
    logic                nr_reg;
    logic [LETTER_W-1:0] ca_reg, cb_reg;

    logic [LETTER_W-1:0] key_code, wr_code, text_a, text_b;
    logic                key_ok, restart, place;
    logic [ALPHABET-1:0] base_used;
    logic [CNT_W-1:0]    base_fill;
    logic [SIDE_W-1:0]   base_row, base_col;
    logic [CELL_AW-1:0]  wr_addr, qa_addr, qb_addr;
    pos_t                qa, qb;

    function automatic logic [SIDE_W-1:0] inc_wrap(input logic [SIDE_W-1:0] v);
        return (v == SIDE_LAST) ? '0 : SIDE_W'(v + 1'b1);
    endfunction

    function automatic logic [CELL_AW-1:0] cell_addr(input pos_t p);
        return CELL_AW'(int'(p.row) * SQUARE_SIDE + int'(p.col));
    endfunction

    assign key_ok   = (item.letter_a < LETTER_W'(ALPHABET));
    assign key_code = (item.letter_a == CODE_J) ? CODE_I : item.letter_a;
    assign text_a   = fold_text(item.letter_a);
    assign text_b   = fold_text(item.letter_b);

    // fill / place
    always_comb
    begin
        wr_code   = cmd.place_key ? key_code : scan_reg;
        restart   = cmd.place_key && key_ok && ready_reg;
        base_used = restart ? '0 : used_reg;
        base_fill = restart ? '0 : fill_reg;
        base_row  = restart ? '0 : row_reg;
        base_col  = restart ? '0 : col_reg;
        place     = ((cmd.place_key && key_ok) ||
                     (cmd.scan_step && scan_reg != CODE_J))
                    && !base_used[wr_code] && (base_fill < CELLS_CNT);
        wr_addr   = cell_addr('{row: base_row, col: base_col});

        used_next  = base_used;
        fill_next  = base_fill;
        row_next   = base_row;
        col_next   = base_col;
        ready_next = restart ? 1'b0 : ready_reg;
        if (place)
        begin
            used_next[wr_code] = 1'b1;
            fill_next          = CNT_W'(base_fill + 1'b1);
            col_next           = inc_wrap(base_col);
            if (base_col == SIDE_LAST) row_next = SIDE_W'(base_row + 1'b1);
        end
        if (cmd.set_ready) ready_next = 1'b1;
        if (cmd.clear)
        begin
            used_next  = '0;
            fill_next  = '0;
            row_next   = '0;
            col_next   = '0;
            ready_next = 1'b0;
        end

        scan_next = scan_reg;
        if (cmd.scan_start)     scan_next = '0;
        else if (cmd.scan_step) scan_next = LETTER_W'(scan_reg + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            fill_reg  <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            ready_reg <= 1'b0;
            scan_reg  <= '0;
        end
        else
        begin
            used_reg  <= used_next;
            fill_reg  <= fill_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            ready_reg <= ready_next;
            scan_reg  <= scan_next;
        end
    end

    // pair mapping from the captured positions
    always_comb
    begin
        if (pa_reg.row == pb_reg.row)
        begin
            qa = '{row: pa_reg.row, col: inc_wrap(pa_reg.col)};
            qb = '{row: pb_reg.row, col: inc_wrap(pb_reg.col)};
        end
        else if (pa_reg.col == pb_reg.col)
        begin
            qa = '{row: inc_wrap(pa_reg.row), col: pa_reg.col};
            qb = '{row: inc_wrap(pb_reg.row), col: pb_reg.col};
        end
        else
        begin
            qa = '{row: pa_reg.row, col: pb_reg.col};
            qb = '{row: pb_reg.row, col: pa_reg.col};
        end
        qa_addr = cell_addr(qa);
        qb_addr = cell_addr(qb);
    end

    always_ff @(posedge clk)
    begin
        if (place)
        begin
            cells_mem[wr_addr] <= wr_code;
            pos_mem[wr_code]   <= '{row: base_row, col: base_col};
        end
        if (cmd.lookup)
        begin
            pa_reg <= pos_mem[text_a];
            pb_reg <= pos_mem[text_b];
            nr_reg <= !ready_reg;
        end
        if (cmd.cell_read)
        begin
            ca_reg <= cells_mem[qa_addr];
            cb_reg <= cells_mem[qb_addr];
        end
    end

    assign stat.ready       = ready_reg;
    assign stat.scan_last   = (scan_reg == CODE_Z);
    assign result.not_ready = nr_reg;
    assign result.cipher_a  = nr_reg ? '0 : ca_reg;
    assign result.cipher_b  = nr_reg ? '0 : cb_reg;

    a_used_matches_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(used_reg) == int'(fill_reg))
        else $error("used letters disagree with fill count");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CELLS_CNT)
        else $error("fill count past square size");

    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> (fill_reg == CELLS_CNT && !used_reg[CODE_J]))
        else $error("square marked ready but not full");

endmodule

>>> rtl/core/playfair_digraph_encryptor.sv
// Top level of the Playfair digraph encryptor: controller plus datapath.
//
// Usage: drive item (func, letter_a, letter_b) and raise start; the beat is
// taken at a rising edge with start high and busy low.
//   start new key : clears the square, no result.
//   key letter    : no result. J folds to I, codes above Z are
//                   ignored, a repeat is dropped, a key letter after finish
//                   begins a new square.
//   finish        : busy while the letter scan fills the free cells in
//                   alphabetical order; no result. No-op when ready.
//   encrypt       : the position table read, then the cell read, with busy
//                   high during the cell read; result_valid pulses for one
//                   cycle once the cells are read. A new beat can be taken
//                   in that same cycle, not before; the two registered reads
//                   (position table, then cells) set the pace of encrypts.
//                   Before finish the result has not_ready set, letters zero.
// The receiver cannot stall: result_valid marks each result for one cycle only.
// Reset clears the used-letter bits, fill count and ready flag; the cell
// and position stores are not cleared and need no sweep.
module playfair_digraph_encryptor #(
    parameter int SQUARE_SIDE = plf_pkg::SQUARE_SIDE_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  plf_pkg::item_t   item,
    output logic             result_valid,
    output plf_pkg::result_t result
);
    import plf_pkg::*;

    ctl_cmd_t  cmd;
    ctl_stat_t stat;

    // sequencer: request decode, letter scan and lookup steps
    plf_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .func         (item.func),
        .stat         (stat),
        .busy         (busy),
        .result_valid (result_valid),
        .cmd          (cmd)
    );

    // square, position table and pair mapping
    plf_datapath #(
        .SQUARE_SIDE (SQUARE_SIDE)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

endmodule
